FILE: rtl/core/zero_run_pixel_line_encoder_top_assert.svh
// Assertion macros shared by the zero-run encoder RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ZERO_RUN_PIXEL_LINE_ENCODER_TOP_ASSERT_SVH
`define ZERO_RUN_PIXEL_LINE_ENCODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZRLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zrle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ZRLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zrle assertion failed");

`endif

FILE: rtl/core/zrle_pkg.sv
// Package for the zero-run pixel line encoder.
// Holds item modes, byte constants and the byte job type; no dependencies.
`timescale 1ns / 1ps

package zrle_pkg;

  // Item modes.
  localparam logic [1:0] MODE_FRAME = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_PIXEL = 2'd2;

  localparam logic [7:0]  SYNC_BYTE = 8'hA5;
  localparam logic [7:0]  RUN_FLAG  = 8'h80;
  localparam int unsigned RUN_W     = 15;
  localparam logic [RUN_W-1:0] RUN_MAX = 15'h7FFF;

  localparam int unsigned JOB_BYTES = 4;
  localparam int unsigned NB_W      = 3;

  // A group of output bytes caused by one item; data[0] goes out first.
  typedef struct packed {
    logic [NB_W-1:0]             nbytes;
    logic [JOB_BYTES-1:0][7:0]   data;
  } zrle_job_t;

endpackage

FILE: rtl/core/zero_run_pixel_line_encoder_top.sv
// Channel | direction | signals
// --------+-----------+-----------------------------------------------
// input   | in        | in_valid_i, in_ready_o, mode_i, value_i, line_end_i
// output  | out       | out_valid_o, out_ready_i, out_byte_o, last_o
//
// An item is accepted whenever the job queue has room; items that cause
// no bytes never enter the queue. Output runs at one byte per cycle while
// out_ready_i is high and a job is queued; an item makes up to four bytes,
// and the output port sets the sustained rate. Reset clears the run counter,
// the queue pointers and count and the output valid flag; no clearing pass
// is needed. Either side may stall freely; the queue keeps the other side moving.
//
// Top level of the zero-run pixel line encoder.
// Depends on zrle_pkg, zrle_front, zrle_fifo and zrle_back.
`timescale 1ns / 1ps

module zero_run_pixel_line_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] value_i,
  input  logic        line_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import zrle_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_valid;
  logic      q_pop;
  zrle_job_t push_job;
  zrle_job_t pop_job;

  // Classification and run tracking.
  zrle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .line_end_i (line_end_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  // Job queue.
  zrle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (pop_job)
  );

  // Byte serializer.
  zrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

FILE: rtl/core/zrle_front.sv
// Front end: accepts items, tracks the zero run and builds byte jobs.
// Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        value_i,
  input  logic               line_end_i,
  input  logic               q_full_i,
  output logic               push_o,
  output zrle_pkg::zrle_job_t job_o
);
  import zrle_pkg::*;

  logic [RUN_W-1:0] zero_run_q, zero_run_d;
  logic [RUN_W-1:0] run_inc;
  logic             accept;
  zrle_job_t        job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Saturating increment of the run counter.
  assign run_inc = (zero_run_q == RUN_MAX) ? RUN_MAX : zero_run_q + {{(RUN_W-1){1'b0}}, 1'b1};

  // Classify the item into a byte job and the next run count.
  always_comb begin
    job        = '0;
    zero_run_d = zero_run_q;
    unique case (mode_i)
      MODE_FRAME: begin
        job.nbytes  = NB_W'(3);
        job.data[0] = SYNC_BYTE;
        job.data[1] = value_i[7:0];
        job.data[2] = value_i[15:8];
        zero_run_d  = '0;
      end
      MODE_LINE: begin
        job.nbytes  = NB_W'(2);
        job.data[0] = value_i[7:0];
        job.data[1] = value_i[15:8];
        zero_run_d  = '0;
      end
      MODE_PIXEL: begin
        if (value_i == 16'd0) begin
          if (line_end_i) begin
            // The counted run is never zero here, so it is always flushed.
            job.nbytes  = NB_W'(2);
            job.data[0] = run_inc[7:0];
            job.data[1] = RUN_FLAG | {1'b0, run_inc[RUN_W-1:8]};
            zero_run_d  = '0;
          end else begin
            zero_run_d = run_inc;
          end
        end else if (zero_run_q != '0) begin
          job.nbytes  = NB_W'(4);
          job.data[0] = zero_run_q[7:0];
          job.data[1] = RUN_FLAG | {1'b0, zero_run_q[RUN_W-1:8]};
          job.data[2] = value_i[7:0];
          job.data[3] = value_i[15:8];
          zero_run_d  = '0;
        end else begin
          job.nbytes  = NB_W'(2);
          job.data[0] = value_i[7:0];
          job.data[1] = value_i[15:8];
          zero_run_d  = '0;
        end
      end
      default: begin
        job = '0;
      end
    endcase
  end

  // Items that cause no bytes are not queued.
  assign push_o = accept && (job.nbytes != '0);
  assign job_o  = job;

  // Run counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= '0;
    end else if (accept) begin
      zero_run_q <= zero_run_d;
    end
  end

endmodule

FILE: rtl/core/zrle_fifo.sv
// Short job queue between the front end and the byte serializer.
// Depends on zrle_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "zero_run_pixel_line_encoder_top_assert.svh"

module zrle_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  zrle_pkg::zrle_job_t job_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output zrle_pkg::zrle_job_t job_o
);
  import zrle_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  zrle_job_t         slots_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = slots_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and count updates, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  `ZRLE_ASSERT_NOW(a_fifo_no_overflow, push_i, !full_o || do_pop)
  `ZRLE_ASSERT_NOW(a_fifo_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
  `ZRLE_ASSERT_NEXT(a_fifo_push_lands, push_i && !do_pop, count_q != '0)

endmodule

FILE: rtl/core/zrle_back.sv
// Back end: serializes queued byte jobs, one byte per cycle while out_ready_i is high, into an output register.
// Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  zrle_pkg::zrle_job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_o
);
  import zrle_pkg::*;

  logic [JOB_BYTES-1:0][7:0] cur_q, cur_d;
  logic [NB_W-1:0]           rem_q, rem_d;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                out_byte_q, out_byte_d;
  logic                      last_q, last_d;
  logic                      out_load;
  logic                      emit;
  logic                      cur_done;

  // The output register takes a new byte when empty or being drained.
  assign out_load = !out_valid_q || out_ready_i;
  assign emit     = out_load && (rem_q != '0);
  assign cur_done = (rem_q == '0) || ((rem_q == NB_W'(1)) && out_load);
  assign pop_o    = job_valid_i && cur_done;

  // Shift register of the current job and the output stage.
  always_comb begin
    cur_d       = cur_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    if (out_load) begin
      out_valid_d = emit;
      out_byte_d  = cur_q[0];
      last_d      = (rem_q == NB_W'(1));
    end
    if (pop_o) begin
      cur_d = job_i.data;
      rem_d = job_i.nbytes;
    end else if (emit) begin
      cur_d = cur_q >> 8;
      rem_d = rem_q - NB_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule
